// File: design/fast_atan2_approx_assert.svh
// Assertion macros for the approximate arctangent block.
// Depends on nothing; users provide i_clk and i_rst_n in scope.
`ifndef FAST_ATAN2_APPROX_ASSERT_SVH
`define FAST_ATAN2_APPROX_ASSERT_SVH
`ifndef SYNTHESIS
`define FA2_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fast_atan2_approx: check failed");
`define FA2_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fast_atan2_approx: check failed");
`else
`define FA2_ASSERT_SAME(label, ante, cons)
`define FA2_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: design/fa2_pkg.sv
// Shared constants, types and helper function of the arctangent pipeline.
// Depends on nothing.
package fa2_pkg;

    // Binary32 constants.
    localparam logic [31:0] COEF_A_BITS  = 32'h3F78EED2;
    localparam logic [31:0] COEF_B_BITS  = 32'hBE448E01;
    localparam logic [31:0] PI_BITS      = 32'h40490FDB;
    localparam logic [31:0] HALF_PI_BITS = 32'h3FC90FDB;
    localparam logic [31:0] CANON_NAN    = 32'h7FC00000;
    localparam logic [31:0] SIGN_MASK    = 32'h80000000;
    localparam int          SIGN_BIT     = 31;
    localparam logic [30:0] INF_MAG      = 31'h7F800000;
    localparam logic [7:0]  EXP_MAX      = 8'hFF;

    // Unrounded value: leading one at bit 26, sticky folded into bit 0.
    typedef struct packed {
        logic              sign;
        logic signed [9:0] exp;
        logic [26:0]       mant;
    } t_unr;

    // Side information that travels with each word down the pipeline.
    typedef struct packed {
        logic        spec;
        logic [31:0] spec_bits;
        logic [31:0] off;
        logic        neg;
        logic [31:0] z;
    } t_tag;

    // Leading zero count of a 48-bit word; 48 when the word is zero.
    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        n = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) begin
                n = 6'(47 - i);
            end
        end
        return n;
    endfunction

endpackage

// File: design/fast_atan2_approx.sv
// Approximate atan2(y, x) on binary32 words, fully pipelined.
// Built from the 28-stage restoring divider and the multiply/add chain,
// with a throughput of one word per cycle.
// busy is never raised and the receiver cannot stall. Synchronous active-low
// reset clears every valid bit; no word is in flight after reset.
// Depends on fa2_pkg, fa2_div, fa2_mul, fa2_add and the assertion header.
`include "fast_atan2_approx_assert.svh"

module fast_atan2_approx (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_y_bits,
    input  logic [31:0] i_x_bits,
    output logic        o_valid,
    output logic [31:0] o_angle_bits
);

    logic          y_nan, x_nan, big;
    logic [31:0]   n_num, n_den, r_num, r_den;
    fa2_pkg::t_tag n_tag, r_tag;
    logic          r_valid;

    logic          div_valid, m1_valid, m2_valid, a1_valid, m3_valid, a2_valid;
    logic [31:0]   div_res, m1_res, m2_res, a1_res, m3_res, a2_res;
    fa2_pkg::t_tag div_tag, z_tag, m1_tag, m2_tag, a1_tag, m3_tag, a2_tag;
    logic          r_out_valid;
    logic [31:0]   r_out;

    assign busy = 1'b0;

    // Classify the operands and choose quotient direction and offset.
    always_comb begin
        y_nan = i_y_bits[30:0] > fa2_pkg::INF_MAG;
        x_nan = i_x_bits[30:0] > fa2_pkg::INF_MAG;
        big   = i_x_bits[30:0] >= i_y_bits[30:0];
        n_num = big ? i_y_bits : i_x_bits;
        n_den = big ? i_x_bits : i_y_bits;
        n_tag.spec      = 1'b0;
        n_tag.spec_bits = fa2_pkg::CANON_NAN;
        n_tag.z         = 32'd0;
        n_tag.neg       = ~big;
        if (big) begin
            n_tag.off = i_x_bits[fa2_pkg::SIGN_BIT]
                      ? (fa2_pkg::PI_BITS | (i_y_bits & fa2_pkg::SIGN_MASK)) : 32'd0;
        end else begin
            n_tag.off = fa2_pkg::HALF_PI_BITS | (i_y_bits & fa2_pkg::SIGN_MASK);
        end
        if (y_nan || x_nan) begin
            n_tag.spec = 1'b1;
        end else if (i_x_bits[30:0] == 31'd0) begin
            n_tag.spec      = 1'b1;
            n_tag.spec_bits = (i_y_bits[30:0] == 31'd0) ? 32'd0
                            : (fa2_pkg::HALF_PI_BITS | (i_y_bits & fa2_pkg::SIGN_MASK));
        end else if ((i_x_bits[30:0] == fa2_pkg::INF_MAG)
                     && (i_y_bits[30:0] == fa2_pkg::INF_MAG)) begin
            // Both infinite: the quotient is not a number.
            n_tag.spec = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= start && !busy;
        end
        r_num <= n_num;
        r_den <= n_den;
        r_tag <= n_tag;
    end

    // Quotient z, kept in the side word for the later products.
    fa2_div u_div (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r_valid),
        .i_n (r_num), .i_d (r_den), .i_tag (r_tag),
        .o_valid (div_valid), .o_res (div_res), .o_tag (div_tag)
    );

    always_comb begin
        z_tag   = div_tag;
        z_tag.z = div_res;
    end

    // Polynomial ((B*z)*z + A)*z, each step rounded.
    fa2_mul u_mul_bz (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (div_valid),
        .i_a (fa2_pkg::COEF_B_BITS), .i_b (div_res), .i_tag (z_tag),
        .o_valid (m1_valid), .o_res (m1_res), .o_tag (m1_tag)
    );

    fa2_mul u_mul_zz (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (m1_valid),
        .i_a (m1_res), .i_b (m1_tag.z), .i_tag (m1_tag),
        .o_valid (m2_valid), .o_res (m2_res), .o_tag (m2_tag)
    );

    fa2_add u_add_a (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (m2_valid),
        .i_a (fa2_pkg::COEF_A_BITS), .i_b (m2_res), .i_tag (m2_tag),
        .o_valid (a1_valid), .o_res (a1_res), .o_tag (a1_tag)
    );

    fa2_mul u_mul_pz (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (a1_valid),
        .i_a (a1_res), .i_b (a1_tag.z), .i_tag (a1_tag),
        .o_valid (m3_valid), .o_res (m3_res), .o_tag (m3_tag)
    );

    // Offset plus or minus the polynomial.
    fa2_add u_add_off (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (m3_valid),
        .i_a (m3_tag.off), .i_b ({m3_res[31] ^ m3_tag.neg, m3_res[30:0]}), .i_tag (m3_tag),
        .o_valid (a2_valid), .o_res (a2_res), .o_tag (a2_tag)
    );

    // Output word register; special cases replace the computed angle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= a2_valid;
        end
        r_out <= a2_tag.spec ? a2_tag.spec_bits : a2_res;
    end

    assign o_valid      = r_out_valid;
    assign o_angle_bits = r_out;

    // The ratio of the smaller to the larger magnitude never exceeds one.
    `FA2_ASSERT_SAME(a_z_le_one, div_valid && !div_tag.spec, div_res[30:0] <= 31'h3F800000)
    // A computed angle stays below four in magnitude.
    `FA2_ASSERT_SAME(a_angle_range, a2_valid && !a2_tag.spec, a2_res[30:23] <= 8'h80)
    // Every finished word reaches the strobe on the next cycle.
    `FA2_ASSERT_NEXT(a_out_follows, a2_valid, o_valid)

endmodule

// File: design/fa2_rnd.sv
// Two-stage round-to-nearest-even and packing of an unrounded binary32 value.
// Depends on fa2_pkg.
module fa2_rnd (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  fa2_pkg::t_unr i_unr,
    input  fa2_pkg::t_tag i_tag,
    output logic          o_valid,
    output logic [31:0]   o_bits,
    output fa2_pkg::t_tag o_tag
);

    logic          n_ovf, r_ovf;
    logic [7:0]    n_ef, r_ef;
    logic [26:0]   n_m, r_m;
    logic          r_sign, r1_valid, r2_valid;
    logic [31:0]   r_bits;
    fa2_pkg::t_tag r1_tag, r2_tag;
    logic [10:0]   sh_full;
    logic [4:0]    sh;
    logic [53:0]   wide;
    logic          inc;
    logic [30:0]   word;

    // Subnormal shift and biased exponent field.
    always_comb begin
        n_ovf   = 1'b0;
        n_m     = i_unr.mant;
        n_ef    = 8'd0;
        sh_full = 11'sd1 - 11'($signed(i_unr.exp));
        sh      = (sh_full > 11'd27) ? 5'd27 : sh_full[4:0];
        wide    = {i_unr.mant, 27'b0} >> sh;
        if ($signed(i_unr.exp) <= 10'sd0) begin
            n_m = {wide[53:28], wide[27] | (|wide[26:0])};
        end else if ($signed(i_unr.exp) >= 10'sd255) begin
            n_ovf = 1'b1;
        end else begin
            n_ef = i_unr.exp[7:0] - 8'd1;
        end
        if (i_unr.mant == 27'd0) begin
            n_ef  = 8'd0;
            n_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
        r_ovf  <= n_ovf;
        r_ef   <= n_ef;
        r_m    <= n_m;
        r_sign <= i_unr.sign;
        r1_tag <= i_tag;
    end

    // Rounding increment; a carry runs on into the exponent field.
    always_comb begin
        inc  = r_m[2] & (r_m[3] | r_m[1] | r_m[0]);
        word = {r_ef, 23'b0} + {7'b0, r_m[26:3]} + {30'b0, inc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r_bits <= r_ovf ? {r_sign, fa2_pkg::EXP_MAX, 23'b0} : {r_sign, word};
        r2_tag <= r1_tag;
    end

    assign o_valid = r2_valid;
    assign o_bits  = r_bits;
    assign o_tag   = r2_tag;

endmodule

// File: design/fa2_mul.sv
// Five-stage binary32 multiplier for finite operands, gradual underflow.
// Depends on fa2_pkg and fa2_rnd.
module fa2_mul (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [31:0]   i_a,
    input  logic [31:0]   i_b,
    input  fa2_pkg::t_tag i_tag,
    output logic          o_valid,
    output logic [31:0]   o_res,
    output fa2_pkg::t_tag o_tag
);

    logic [7:0]        ea, eb;
    logic [23:0]       ma, mb;
    logic              r1_valid, r2_valid, r3_valid;
    logic              r1_sign, r2_sign;
    logic signed [9:0] r1_e, r2_e;
    logic [47:0]       r1_p, r2_p, n_p, shp;
    logic [5:0]        r2_lz;
    fa2_pkg::t_tag     r1_tag, r2_tag, r3_tag;
    fa2_pkg::t_unr     n_unr, r_unr;

    // Unpack and form the mantissa product.
    always_comb begin
        ea  = (i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23];
        eb  = (i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23];
        ma  = {i_a[30:23] != 8'd0, i_a[22:0]};
        mb  = {i_b[30:23] != 8'd0, i_b[22:0]};
        n_p = ma * mb;
    end

    // Normalising shift of the product.
    always_comb begin
        shp        = r2_p << r2_lz;
        n_unr.sign = r2_sign;
        n_unr.exp  = r2_e - $signed({4'b0, r2_lz});
        n_unr.mant = {shp[47:22], shp[21] | (|shp[20:0])};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
        r1_sign <= i_a[31] ^ i_b[31];
        r1_e    <= $signed({2'b00, ea}) + $signed({2'b00, eb}) - 10'sd126;
        r1_p    <= n_p;
        r1_tag  <= i_tag;
        r2_sign <= r1_sign;
        r2_e    <= r1_e;
        r2_p    <= r1_p;
        r2_lz   <= fa2_pkg::lzc48(r1_p);
        r2_tag  <= r1_tag;
        r_unr   <= n_unr;
        r3_tag  <= r2_tag;
    end

    fa2_rnd u_rnd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_valid),
        .i_unr   (r_unr),
        .i_tag   (r3_tag),
        .o_valid (o_valid),
        .o_bits  (o_res),
        .o_tag   (o_tag)
    );

endmodule

// File: design/fa2_add.sv
// Seven-stage binary32 adder for finite operands, gradual underflow.
// Depends on fa2_pkg and fa2_rnd.
module fa2_add (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [31:0]   i_a,
    input  logic [31:0]   i_b,
    input  fa2_pkg::t_tag i_tag,
    output logic          o_valid,
    output logic [31:0]   o_res,
    output fa2_pkg::t_tag o_tag
);

    logic [31:0]   big, sml;
    logic [7:0]    e_big, e_sml;
    logic [4:0]    shamt;
    logic [53:0]   wide;
    logic [27:0]   shs;
    logic [4:0]    r_valid;
    fa2_pkg::t_tag r_tag [0:4];
    logic          r1_sign, r1_sub, r2_sign, r2_sub, r3_sign, r3_sub, r4_sign, r4_sub;
    logic [7:0]    r1_e, r2_e, r3_e, r4_e, r1_d;
    logic [23:0]   r1_mb, r1_ms;
    logic [26:0]   r2_mb, r2_ms;
    logic [27:0]   r3_s, r4_s;
    logic [5:0]    r4_lz;
    fa2_pkg::t_unr n_unr, r_unr;

    // Order by magnitude and find the exponent difference.
    always_comb begin
        if (i_b[30:0] > i_a[30:0]) begin
            big = i_b;
            sml = i_a;
        end else begin
            big = i_a;
            sml = i_b;
        end
        e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        e_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    end

    // Alignment of the smaller operand with a sticky bit.
    always_comb begin
        shamt = (r1_d > 8'd27) ? 5'd27 : r1_d[4:0];
        wide  = {r1_ms, 3'b0, 27'b0} >> shamt;
    end

    // Normalisation; an exact cancellation gives +0.
    always_comb begin
        shs        = r4_s << r4_lz;
        n_unr.sign = r4_sign;
        n_unr.exp  = $signed({2'b00, r4_e}) + 10'sd1 - $signed({4'b0, r4_lz});
        n_unr.mant = {shs[27:2], shs[1] | shs[0]};
        if (r4_s == 28'd0) begin
            n_unr.sign = r4_sign & ~r4_sub;
            n_unr.mant = 27'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 5'd0;
        end else begin
            r_valid <= {r_valid[3:0], i_valid};
        end
        r_tag[0] <= i_tag;
        for (int k = 1; k < 5; k++) begin
            r_tag[k] <= r_tag[k-1];
        end
        r1_sign <= big[31];
        r1_sub  <= i_a[31] ^ i_b[31];
        r1_e    <= e_big;
        r1_d    <= e_big - e_sml;
        r1_mb   <= {big[30:23] != 8'd0, big[22:0]};
        r1_ms   <= {sml[30:23] != 8'd0, sml[22:0]};
        r2_sign <= r1_sign;
        r2_sub  <= r1_sub;
        r2_e    <= r1_e;
        r2_mb   <= {r1_mb, 3'b0};
        r2_ms   <= {wide[53:28], wide[27] | (|wide[26:0])};
        r3_sign <= r2_sign;
        r3_sub  <= r2_sub;
        r3_e    <= r2_e;
        r3_s    <= r2_sub ? ({1'b0, r2_mb} - {1'b0, r2_ms}) : ({1'b0, r2_mb} + {1'b0, r2_ms});
        r4_sign <= r3_sign;
        r4_sub  <= r3_sub;
        r4_e    <= r3_e;
        r4_s    <= r3_s;
        r4_lz   <= fa2_pkg::lzc48({r3_s, 20'b0});
        r_unr   <= n_unr;
    end

    fa2_rnd u_rnd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_valid[4]),
        .i_unr   (r_unr),
        .i_tag   (r_tag[4]),
        .o_valid (o_valid),
        .o_bits  (o_res),
        .o_tag   (o_tag)
    );

endmodule

// File: design/fa2_div.sv
// Binary32 divider for |n| <= |d|: one restoring quotient bit per stage.
// Depends on fa2_pkg and fa2_rnd. A zero numerator or infinite divisor gives zero.
module fa2_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [31:0]   i_n,
    input  logic [31:0]   i_d,
    input  fa2_pkg::t_tag i_tag,
    output logic          o_valid,
    output logic [31:0]   o_res,
    output fa2_pkg::t_tag o_tag
);

    localparam int DIV_STEPS = 28;

    typedef struct packed {
        logic              valid;
        logic [24:0]       rem;
        logic [27:0]       q;
        logic [23:0]       md;
        logic signed [9:0] e;
        logic              zero;
        logic              sign;
        fa2_pkg::t_tag     tag;
    } t_dst;

    logic              r1_valid, r1_zero, r1_sign;
    logic [23:0]       r1_mn, r1_md;
    logic [5:0]        r1_lzn, r1_lzd;
    logic [7:0]        r1_en, r1_ed;
    fa2_pkg::t_tag     r1_tag;
    t_dst              n_first;
    t_dst              r_st [0:DIV_STEPS];
    t_dst              n_st [0:DIV_STEPS-1];
    logic              sticky;
    fa2_pkg::t_unr     n_unr, r_unr;
    logic              r_fvalid;
    fa2_pkg::t_tag     r_ftag;
    logic [23:0]       mn, md;

    // Unpack; subnormal mantissas get their leading zero counts.
    always_comb begin
        mn = {i_n[30:23] != 8'd0, i_n[22:0]};
        md = {i_d[30:23] != 8'd0, i_d[22:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
        r1_zero <= (i_n[30:0] == 31'd0) || (i_d[30:23] == fa2_pkg::EXP_MAX);
        r1_sign <= i_n[31] ^ i_d[31];
        r1_mn   <= mn;
        r1_md   <= md;
        r1_lzn  <= fa2_pkg::lzc48({mn, 24'b0});
        r1_lzd  <= fa2_pkg::lzc48({md, 24'b0});
        r1_en   <= (i_n[30:23] == 8'd0) ? 8'd1 : i_n[30:23];
        r1_ed   <= (i_d[30:23] == 8'd0) ? 8'd1 : i_d[30:23];
        r1_tag  <= i_tag;
    end

    // Normalise both mantissas and form the quotient exponent.
    always_comb begin
        n_first.valid = r1_valid;
        n_first.rem   = {1'b0, r1_mn << r1_lzn};
        n_first.q     = 28'd0;
        n_first.md    = r1_md << r1_lzd;
        n_first.e     = $signed({2'b00, r1_en}) - $signed({4'b0, r1_lzn})
                        - $signed({2'b00, r1_ed}) + $signed({4'b0, r1_lzd}) + 10'sd127;
        n_first.zero  = r1_zero;
        n_first.sign  = r1_sign;
        n_first.tag   = r1_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st[0].valid <= 1'b0;
        end else begin
            r_st[0] <= n_first;
        end
    end

    // Restoring steps, one quotient bit each.
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic        ge;
        logic [24:0] diff;

        always_comb begin
            n_st[k]     = r_st[k];
            ge          = r_st[k].rem >= {1'b0, r_st[k].md};
            diff        = ge ? (r_st[k].rem - {1'b0, r_st[k].md}) : r_st[k].rem;
            n_st[k].rem = {diff[23:0], 1'b0};
            n_st[k].q   = {r_st[k].q[26:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[k+1].valid <= 1'b0;
            end else begin
                r_st[k+1] <= n_st[k];
            end
        end
    end

    // Place the quotient with its leading one at bit 26.
    always_comb begin
        sticky     = r_st[DIV_STEPS].rem != 25'd0;
        n_unr.sign = r_st[DIV_STEPS].sign;
        if (r_st[DIV_STEPS].q[27]) begin
            n_unr.exp  = r_st[DIV_STEPS].e;
            n_unr.mant = {r_st[DIV_STEPS].q[27:2],
                          r_st[DIV_STEPS].q[1] | r_st[DIV_STEPS].q[0] | sticky};
        end else begin
            n_unr.exp  = r_st[DIV_STEPS].e - 10'sd1;
            n_unr.mant = {r_st[DIV_STEPS].q[26:1], r_st[DIV_STEPS].q[0] | sticky};
        end
        if (r_st[DIV_STEPS].zero) begin
            n_unr.mant = 27'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvalid <= 1'b0;
        end else begin
            r_fvalid <= r_st[DIV_STEPS].valid;
        end
        r_unr  <= n_unr;
        r_ftag <= r_st[DIV_STEPS].tag;
    end

    fa2_rnd u_rnd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_fvalid),
        .i_unr   (r_unr),
        .i_tag   (r_ftag),
        .o_valid (o_valid),
        .o_bits  (o_res),
        .o_tag   (o_tag)
    );

endmodule
